@@ hdl/base32_style_byte_encoder_unit_macros.svh @@
// Assertion macros for the base32-style byte encoder.
// Included by the top level; no other dependencies.
`ifndef BASE32_STYLE_BYTE_ENCODER_UNIT_MACROS_SVH
`define BASE32_STYLE_BYTE_ENCODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define B32ENC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b32enc assertion failed");
`define B32ENC_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("b32enc assertion failed");
`else
`define B32ENC_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define B32ENC_ASSERT_NEXT(lbl, clk, ante, cons)
`endif

`endif

@@ hdl/b32enc_pkg.sv @@
// Shared types and constants of the base32-style byte encoder.
// No dependencies.
`default_nettype none

package b32enc_pkg;

    localparam int CHAR_W  = 7;
    localparam int CHUNK_W = 5;
    localparam int MAX_RES = 3;

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    localparam logic [0:0] REG_RAW_OUTPUT  = 1'd0;
    localparam logic [0:0] REG_LINE_LENGTH = 1'd1;

    localparam logic [7:0]         LINE_LENGTH_RESET = 8'd72;
    localparam logic [7:0]         COUNT_MAX         = 8'd255;
    localparam logic [CHAR_W-1:0]  NEWLINE_CODE      = 7'd10;
    localparam logic [CHAR_W-1:0]  CHAR_A            = 7'd65;
    localparam logic [CHAR_W-1:0]  CHAR_0            = 7'd48;
    localparam logic [CHUNK_W-1:0] ALPHA_LEN         = 5'd26;

    typedef struct packed {
        logic [1:0]                      n;
        logic [MAX_RES-1:0][CHAR_W-1:0]  chars;
    } entry_t;

endpackage

`default_nettype wire

@@ hdl/base32_style_byte_encoder_unit.sv @@
// Base32-style byte encoder: bytes in, one 7-bit character per output beat,
// with newlines every line_length characters (alphabet mode) and a flush on
// an end beat (s_tuser high). The front accepts one input beat per cycle
// while the result queue (QUEUE_DEPTH entries) has room; the output stage
// sends one character per cycle while m_tready allows; an item yields 1 to
// 3 results for a data byte and 0 to 2 for an end beat, newlines included.
// Results of one item end with m_tlast.
// Depends on b32enc_pkg, b32enc_front, b32enc_queue, b32enc_back and the
// assertion macro header.
`default_nettype none

`include "base32_style_byte_encoder_unit_macros.svh"

module base32_style_byte_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [0:0] cfg_addr,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tuser,   // [0] func
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [6:0] out_char, [7] zero
    output logic            m_tlast
);

    b32enc_pkg::entry_t wr_entry, rd_entry;
    logic q_push, q_pop, q_full, q_empty;

    b32enc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_push      (q_push),
        .q_entry     (wr_entry),
        .q_full      (q_full)
    );

    b32enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_entry (rd_entry),
        .empty    (q_empty)
    );

    b32enc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_entry  (rd_entry),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `B32ENC_ASSERT_SAME(a_push_not_full, aclk, aresetn, q_push, !q_full)
    `B32ENC_ASSERT_SAME(a_pop_not_empty, aclk, aresetn, q_pop, !q_empty)
    `B32ENC_ASSERT_SAME(a_entry_nonempty, aclk, aresetn, q_push, wr_entry.n != 2'd0)
    `B32ENC_ASSERT_NEXT(a_reset_clears_out, aclk, !aresetn, !m_tvalid)

endmodule

`default_nettype wire

@@ hdl/b32enc_queue.sv @@
// Small result queue between the encoder front and the output back end.
// Depends on b32enc_pkg.
`default_nettype none

module b32enc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_en,
    input  wire b32enc_pkg::entry_t wr_entry,
    output logic                  full,
    input  wire logic             rd_en,
    output b32enc_pkg::entry_t    rd_entry,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b32enc_pkg::entry_t slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (!wr_en && rd_en) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slots[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

@@ hdl/b32enc_front.sv @@
// Encoder front: configuration registers, input beat intake, chunking,
// alphabet mapping and line counting; emits one queue entry per item that yields results.
// Depends on b32enc_pkg.
`default_nettype none

module b32enc_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [0:0]       cfg_addr,
    input  wire logic [7:0]       cfg_wr_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             s_tuser,
    output logic                  q_push,
    output b32enc_pkg::entry_t    q_entry,
    input  wire logic             q_full
);

    localparam int CW = b32enc_pkg::CHAR_W;

    logic       raw_reg;
    logic [7:0] line_len_reg;
    logic [3:0] lb_reg, lb_next;
    logic [2:0] lcnt_reg, lcnt_next;
    logic [7:0] line_cnt_reg, line_cnt_next;

    logic        accept;
    logic [2:0]  m_c;
    logic [11:0] x;
    logic [3:0]  mm, sh0, sh1;
    logic        two;
    logic [4:0]  c0, c1, ce, cf;
    logic [2:0]  m_new;
    logic [3:0]  lb_new;
    logic        has_end_chunk, send_a;
    logic [7:0]  lc1, lc_a, lc2, lc_b, lc_a_eff;
    logic        nl_a, nl_b;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == b32enc_pkg::COUNT_MAX) ? v : 8'(v + 1'b1);
    endfunction

    function automatic logic [CW-1:0] to_char(input logic raw, input logic [4:0] v);
        if (raw) begin
            return CW'(v);
        end else if (v < b32enc_pkg::ALPHA_LEN) begin
            return CW'(CW'(v) + b32enc_pkg::CHAR_A);
        end else begin
            return CW'(CW'(5'(v - b32enc_pkg::ALPHA_LEN)) + b32enc_pkg::CHAR_0);
        end
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        m_c    = (lcnt_reg > 3'd4) ? 3'd4 : lcnt_reg;
        x      = {lb_reg, s_tdata};
        mm     = 4'({1'b0, m_c} + 4'd8);
        sh0    = 4'(mm - 4'd5);
        sh1    = 4'(mm - 4'd10);
        two    = (mm >= 4'd10);
        c0     = 5'(x >> sh0);
        c1     = 5'(x >> sh1);
        m_new  = two ? 3'(sh1) : 3'(sh0);
        lb_new = x[3:0] & 4'((5'd1 << m_new) - 5'd1);
        ce     = 5'({5'b0, lb_reg} << (3'd5 - m_c));

        has_end_chunk = (m_c != 3'd0);
        send_a        = (s_tuser == b32enc_pkg::FUNC_DATA) || has_end_chunk;
        cf            = (s_tuser == b32enc_pkg::FUNC_DATA) ? c0 : ce;

        lc1      = sat_inc(line_cnt_reg);
        nl_a     = !raw_reg && (lc1 >= line_len_reg);
        lc_a     = nl_a ? 8'd0 : lc1;
        lc_a_eff = send_a ? lc_a : line_cnt_reg;
        lc2      = sat_inc(lc_a);
        nl_b     = !raw_reg && (lc2 >= line_len_reg) && !nl_a;
        lc_b     = nl_b ? 8'd0 : lc2;

        q_entry = '0;
        if (s_tuser == b32enc_pkg::FUNC_DATA) begin
            q_entry.chars[0] = to_char(raw_reg, cf);
            if (nl_a) begin
                q_entry.chars[1] = b32enc_pkg::NEWLINE_CODE;
                q_entry.chars[2] = to_char(raw_reg, c1);
                q_entry.n        = two ? 2'd3 : 2'd2;
            end else begin
                q_entry.chars[1] = to_char(raw_reg, c1);
                q_entry.chars[2] = b32enc_pkg::NEWLINE_CODE;
                q_entry.n        = 2'(2'd1 + {1'b0, two} + {1'b0, two && nl_b});
            end
        end else if (has_end_chunk) begin
            q_entry.chars[0] = to_char(raw_reg, cf);
            q_entry.chars[1] = b32enc_pkg::NEWLINE_CODE;
            q_entry.n        = (nl_a || (lc_a_eff != 8'd0)) ? 2'd2 : 2'd1;
        end else begin
            q_entry.chars[0] = b32enc_pkg::NEWLINE_CODE;
            q_entry.n        = (line_cnt_reg != 8'd0) ? 2'd1 : 2'd0;
        end

        q_push = accept && (q_entry.n != 2'd0);

        lb_next       = lb_reg;
        lcnt_next     = lcnt_reg;
        line_cnt_next = line_cnt_reg;
        if (accept) begin
            if (s_tuser == b32enc_pkg::FUNC_DATA) begin
                lb_next       = lb_new;
                lcnt_next     = m_new;
                line_cnt_next = two ? lc_b : lc_a;
            end else begin
                lb_next       = '0;
                lcnt_next     = '0;
                line_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg      <= 1'b0;
            line_len_reg <= b32enc_pkg::LINE_LENGTH_RESET;
            lb_reg       <= '0;
            lcnt_reg     <= '0;
            line_cnt_reg <= '0;
        end else begin
            lb_reg       <= lb_next;
            lcnt_reg     <= lcnt_next;
            line_cnt_reg <= line_cnt_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    b32enc_pkg::REG_RAW_OUTPUT:  raw_reg      <= cfg_wr_data[0];
                    b32enc_pkg::REG_LINE_LENGTH: line_len_reg <= cfg_wr_data;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/b32enc_back.sv @@
// Encoder back end: drains queue entries one character per beat into the
// registered output stage. Depends on b32enc_pkg.
`default_nettype none

module b32enc_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire b32enc_pkg::entry_t q_entry,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);

    localparam int CW = b32enc_pkg::CHAR_W;

    b32enc_pkg::entry_t cur_reg;
    logic               cur_valid_reg;
    logic [1:0]         idx_reg;
    logic               m_valid_reg;
    logic [CW-1:0]      m_data_reg;
    logic               m_last_reg;

    logic out_free, emit, at_end, cur_done;

    assign out_free = !m_valid_reg || m_tready;
    assign emit     = out_free && cur_valid_reg;
    assign at_end   = (idx_reg == 2'(cur_reg.n - 2'd1));
    assign cur_done = emit && at_end;
    assign q_pop    = !q_empty && (!cur_valid_reg || cur_done);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};
    assign m_tlast  = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end else if (cur_done) begin
                cur_valid_reg <= 1'b0;
            end else if (emit) begin
                idx_reg <= 2'(idx_reg + 1'b1);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_entry;
        end
        if (emit) begin
            m_data_reg <= cur_reg.chars[idx_reg];
            m_last_reg <= at_end;
        end
    end

endmodule

`default_nettype wire
